// File: src/tdpu_pkg.sv
// Package for the Thumb data-processing unit: field widths, opcode codes, shared types.
// Used by tdpu_exec, thumb_data_processing_unit and the bench; depends on nothing.
package tdpu_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned IdxW = 3;
	localparam int unsigned InsW = 16;

	typedef enum logic [3:0] {
		ALU_AND = 4'h0, ALU_EOR = 4'h1, ALU_LSL = 4'h2, ALU_LSR = 4'h3,
		ALU_ASR = 4'h4, ALU_ADC = 4'h5, ALU_SBC = 4'h6, ALU_ROR = 4'h7,
		ALU_TST = 4'h8, ALU_NEG = 4'h9, ALU_CMP = 4'hA, ALU_CMN = 4'hB,
		ALU_ORR = 4'hC, ALU_MUL = 4'hD, ALU_BIC = 4'hE, ALU_MVN = 4'hF
	} alu_op_t;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	typedef struct packed {
		logic [DataW-1:0] result_value;
		logic [IdxW-1:0]  dest_register;
		logic             register_written;
		logic             flag_negative;
		logic             flag_zero;
		logic             flag_carry;
		logic             flag_overflow;
		logic             unhandled;
	} result_t;

	typedef struct packed {
		logic             command;
		logic [InsW-1:0]  instruction;
		logic [IdxW-1:0]  load_index;
		logic [DataW-1:0] load_value;
	} item_t;

	// ARM shifter: amount 0 keeps value and carry
	function automatic logic [DataW:0] shift_op(input logic [1:0] kind,
			input logic [DataW-1:0] x, input logic [8:0] amt, input logic cin);
		logic [DataW-1:0] r;
		logic c;
		logic [4:0] m;
		logic [63:0] w;
		r = x;
		c = cin;
		m = amt[4:0];
		w = '0;
		if (amt != 9'd0) begin
			unique case (kind)
				SH_LSL: begin
					if (amt < 9'd32) begin
						w = {32'd0, x} << m;
						r = w[31:0];
						c = w[32];
					end else begin
						r = '0;
						c = (amt == 9'd32) ? x[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (amt < 9'd32) begin
						w = {x, 32'd0} >> m;
						r = w[63:32];
						c = w[31];
					end else begin
						r = '0;
						c = (amt == 9'd32) ? x[31] : 1'b0;
					end
				end
				SH_ASR: begin
					if (amt < 9'd32) begin
						w = $signed({x, 32'd0}) >>> m;
						r = w[63:32];
						c = w[31];
					end else begin
						r = {DataW{x[31]}};
						c = x[31];
					end
				end
				default: begin
					w = {x, x} >> m;
					r = w[31:0];
					c = r[31];
				end
			endcase
		end
		return {c, r};
	endfunction
endpackage

// File: src/tdpu_if.sv
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; instantiated with tdpu_pkg types.
interface tdpu_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/tdpu_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module tdpu_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_a,
	output logic [Width-1:0]         rdata_b
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// File: src/tdpu_exec.sv
// Execute logic: decodes one Thumb word and computes result and NZCV.
// Depends on tdpu_pkg.
module tdpu_exec (
	input  tdpu_pkg::item_t          item,
	input  logic [tdpu_pkg::DataW-1:0] rs_val,
	input  logic [tdpu_pkg::DataW-1:0] rd_val,
	input  logic [3:0]               flags,
	output tdpu_pkg::result_t        res
);
	logic [15:0] ins;
	logic cf, vf;
	logic [tdpu_pkg::DataW-1:0] r, b;
	logic [tdpu_pkg::DataW:0] sh;
	logic [tdpu_pkg::DataW:0] sum;
	logic [63:0] prod;
	logic c, v, wr, unh, logic_op;
	logic [8:0] amt;
	logic [2:0] dst;
	tdpu_pkg::alu_op_t aop;

	always_comb begin
		ins = item.instruction;
		cf = flags[1];
		vf = flags[0];
		r = '0;
		b = '0;
		c = cf;
		v = vf;
		wr = 1'b0;
		unh = 1'b0;
		logic_op = 1'b0;
		dst = ins[2:0];
		amt = '0;
		sh = '0;
		sum = '0;
		prod = '0;
		aop = tdpu_pkg::alu_op_t'(ins[9:6]);
		if (item.command) begin
			dst = item.load_index;
			r = item.load_value;
			wr = 1'b1;
			logic_op = 1'b1;
			c = cf;
		end else if (ins[15:13] == 3'b000 && ins[12:11] != 2'b11) begin
			amt = {4'd0, ins[10:6]};
			if (ins[12:11] != tdpu_pkg::SH_LSL && ins[10:6] == 5'd0) amt = 9'd32;
			sh = tdpu_pkg::shift_op(ins[12:11], rs_val, amt, cf);
			r = sh[31:0];
			c = sh[32];
			wr = 1'b1;
		end else if (ins[15:11] == 5'b00011) begin
			b = ins[10] ? {29'd0, ins[8:6]} : rd_val;
			wr = 1'b1;
			if (ins[9]) begin
				sum = {1'b0, rs_val} + {1'b0, ~b} + 33'd1;
				v = (rs_val[31] ^ b[31]) & (rs_val[31] ^ sum[31]);
			end else begin
				sum = {1'b0, rs_val} + {1'b0, b};
				v = (rs_val[31] ^ sum[31]) & (b[31] ^ sum[31]);
			end
			r = sum[31:0];
			c = sum[32];
		end else if (ins[15:13] == 3'b001) begin
			dst = ins[10:8];
			b = {24'd0, ins[7:0]};
			wr = (ins[12:11] != 2'd1);
			if (ins[12:11] == 2'd0) begin
				r = b;
			end else if (ins[12:11] == 2'd2) begin
				sum = {1'b0, rd_val} + {1'b0, b};
				v = (rd_val[31] ^ sum[31]) & (b[31] ^ sum[31]);
				r = sum[31:0];
				c = sum[32];
			end else begin
				sum = {1'b0, rd_val} + {1'b0, ~b} + 33'd1;
				v = (rd_val[31] ^ b[31]) & (rd_val[31] ^ sum[31]);
				r = sum[31:0];
				c = sum[32];
			end
		end else if (ins[15:10] == 6'b010000) begin
			wr = 1'b1;
			amt = {1'b0, rs_val[7:0]};
			unique case (aop)
				tdpu_pkg::ALU_AND, tdpu_pkg::ALU_TST: r = rd_val & rs_val;
				tdpu_pkg::ALU_EOR: r = rd_val ^ rs_val;
				tdpu_pkg::ALU_ORR: r = rd_val | rs_val;
				tdpu_pkg::ALU_BIC: r = rd_val & ~rs_val;
				tdpu_pkg::ALU_MVN: r = ~rs_val;
				tdpu_pkg::ALU_LSL: begin
					sh = tdpu_pkg::shift_op(tdpu_pkg::SH_LSL, rd_val, amt, cf);
					r = sh[31:0];
					c = sh[32];
				end
				tdpu_pkg::ALU_LSR: begin
					sh = tdpu_pkg::shift_op(tdpu_pkg::SH_LSR, rd_val, amt, cf);
					r = sh[31:0];
					c = sh[32];
				end
				tdpu_pkg::ALU_ASR: begin
					sh = tdpu_pkg::shift_op(tdpu_pkg::SH_ASR, rd_val, amt, cf);
					r = sh[31:0];
					c = sh[32];
				end
				tdpu_pkg::ALU_ROR: begin
					sh = tdpu_pkg::shift_op(tdpu_pkg::SH_ROR, rd_val, amt, cf);
					r = sh[31:0];
					c = sh[32];
				end
				tdpu_pkg::ALU_ADC: begin
					sum = {1'b0, rd_val} + {1'b0, rs_val} + {32'd0, cf};
					v = (rd_val[31] ^ sum[31]) & (rs_val[31] ^ sum[31]);
					r = sum[31:0];
					c = sum[32];
				end
				tdpu_pkg::ALU_CMN: begin
					sum = {1'b0, rd_val} + {1'b0, rs_val};
					v = (rd_val[31] ^ sum[31]) & (rs_val[31] ^ sum[31]);
					r = sum[31:0];
					c = sum[32];
				end
				tdpu_pkg::ALU_SBC: begin
					sum = {1'b0, rd_val} + {1'b0, ~rs_val} + {32'd0, cf};
					v = (rd_val[31] ^ rs_val[31]) & (rd_val[31] ^ sum[31]);
					r = sum[31:0];
					c = sum[32];
				end
				tdpu_pkg::ALU_CMP: begin
					sum = {1'b0, rd_val} + {1'b0, ~rs_val} + 33'd1;
					v = (rd_val[31] ^ rs_val[31]) & (rd_val[31] ^ sum[31]);
					r = sum[31:0];
					c = sum[32];
				end
				tdpu_pkg::ALU_NEG: begin
					sum = {1'b0, ~rs_val} + 33'd1;
					v = rs_val[31] & sum[31];
					r = sum[31:0];
					c = sum[32];
				end
				tdpu_pkg::ALU_MUL: begin
					prod = rd_val * rs_val;
					r = prod[31:0];
					c = 1'b0;
				end
				default: r = '0;
			endcase
			if (aop == tdpu_pkg::ALU_TST || aop == tdpu_pkg::ALU_CMP
					|| aop == tdpu_pkg::ALU_CMN) begin
				wr = 1'b0;
			end
		end else begin
			unh = 1'b1;
			dst = '0;
		end
		res.result_value = r;
		res.dest_register = dst;
		res.register_written = wr;
		res.unhandled = unh;
		if (unh || logic_op) begin
			{res.flag_negative, res.flag_zero, res.flag_carry, res.flag_overflow} = flags;
		end else begin
			res.flag_negative = r[31];
			res.flag_zero = (r == '0);
			res.flag_carry = c;
			res.flag_overflow = v;
		end
	end
endmodule

// File: src/thumb_data_processing_unit.sv
// Top level of the Thumb data-processing unit: register file RAM, execute stage, output register.
// Depends on tdpu_pkg, tdpu_if, tdpu_ram, tdpu_exec.
//
//  channel | direction | payload
//  in_ch   | sink      | command, instruction, load_index, load_value
//  out_ch  | source    | result_value, dest_register, register_written, N Z C V, unhandled
//
// The item and its Rs/Rd reads from the RAM are registered; the execute stage then computes and writes back.
// One item per cycle sustained while the output is taken; a write-back is forwarded to the next item's reads.
// Registers come from a valid bit per entry after reset, so reads of unwritten entries give 0.
// The pipeline stalls only when the output register holds an item that is not taken.
module thumb_data_processing_unit #(
	parameter int unsigned REG_COUNT = 8
) (
	input logic clk,
	input logic arst_n,
	tdpu_if.sink   in_ch,
	tdpu_if.source out_ch
);
	localparam int unsigned AW = $clog2(REG_COUNT);

	tdpu_pkg::item_t item_s1;
	logic vld_s1;
	logic [AW-1:0] ra_s1, rb_s1;
	logic [REG_COUNT-1:0] valid_q;
	logic [3:0] flags_q;
	logic [31:0] ram_a, ram_b, rs_val, rd_val;
	logic [AW-1:0] ra, rb;
	logic advance, fire_s1;
	logic we;
	tdpu_pkg::result_t res;
	tdpu_pkg::result_t out_q;
	logic out_vld_q;

	assign advance = !out_vld_q || out_ch.ready;
	assign in_ch.ready = advance;
	assign fire_s1 = vld_s1 && advance;

	// source register in bits 5:3, second register per format (Rd, or Rn for add/sub)
	always_comb begin
		ra = AW'(in_ch.data.instruction[5:3]);
		rb = AW'(in_ch.data.instruction[2:0]);
		if (in_ch.data.instruction[15:11] == 5'b00011) begin
			rb = AW'(in_ch.data.instruction[8:6]);
		end else if (in_ch.data.instruction[15:13] == 3'b001) begin
			rb = AW'(in_ch.data.instruction[10:8]);
		end
	end

	assign we = fire_s1 && res.register_written;

	tdpu_ram #(.Width(32), .Depth(REG_COUNT)) u_regs (
		.clk(clk), .we(we), .waddr(AW'(res.dest_register)), .wdata(res.result_value),
		.re(advance), .raddr_a(ra), .raddr_b(rb), .rdata_a(ram_a), .rdata_b(ram_b)
	);

	// forward a write made while this item's read was under way
	logic fwd_a_q, fwd_b_q;
	logic [31:0] fwd_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else if (advance) begin
			fwd_a_q <= we && AW'(res.dest_register) == ra;
			fwd_b_q <= we && AW'(res.dest_register) == rb;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_d_q <= res.result_value;
		end
	end

	assign rs_val = fwd_a_q ? fwd_d_q : (valid_q[ra_s1] ? ram_a : '0);
	assign rd_val = fwd_b_q ? fwd_d_q : (valid_q[rb_s1] ? ram_b : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= in_ch.data;
			ra_s1 <= ra;
			rb_s1 <= rb;
		end
	end

	tdpu_exec u_exec (
		.item(item_s1), .rs_val(rs_val), .rd_val(rd_val), .flags(flags_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			flags_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[AW'(res.dest_register)] <= 1'b1;
			end
			if (fire_s1) begin
				flags_q <= {res.flag_negative, res.flag_zero, res.flag_carry,
					res.flag_overflow};
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;
endmodule

// File: bench/tb_thumb_data_processing_unit.sv
// Self-checking bench for the Thumb data-processing unit: random and directed items,
// a behavioral predictor of registers and flags, and a scoreboard of expected results.
// Depends on tdpu_pkg, tdpu_if and thumb_data_processing_unit.
module tb_thumb_data_processing_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;

	tdpu_if #(.T(tdpu_pkg::item_t)) in_ch ();
	tdpu_if #(.T(tdpu_pkg::result_t)) out_ch ();

	thumb_data_processing_unit dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always #5 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	class alu_scoreboard;
		logic [31:0] regs [8];
		logic [3:0] nzcv;
		tdpu_pkg::result_t pending [$];

		function new();
			foreach (regs[i]) regs[i] = '0;
			nzcv = '0;
		endfunction

		function automatic logic [3:0] nz(logic [31:0] r, logic c, logic v);
			return {r[31], r == 32'd0, c, v};
		endfunction

		function automatic logic [3:0] add(logic [31:0] a, logic [31:0] b, logic ci,
				output logic [31:0] r);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b} + {32'd0, ci};
			r = s[31:0];
			return nz(r, s[32], (a[31] ^ r[31]) & (b[31] ^ r[31]));
		endfunction

		function automatic logic [3:0] sub(logic [31:0] a, logic [31:0] b, logic bw,
				output logic [31:0] r);
			r = a - b - {31'd0, bw};
			return nz(r, {1'b0, a} >= ({1'b0, b} + {32'd0, bw}),
				(a[31] ^ b[31]) & (a[31] ^ r[31]));
		endfunction

		function automatic logic [31:0] shifter(logic [1:0] kind, logic [31:0] x,
				int unsigned amt, logic ci, output logic co);
			logic [31:0] r;
			int unsigned m;
			co = ci;
			r = x;
			if (amt != 0) begin
				case (kind)
					tdpu_pkg::SH_LSL: begin
						if (amt < 32) begin co = x[32-amt]; r = x << amt; end
						else begin co = (amt == 32) ? x[0] : 1'b0; r = '0; end
					end
					tdpu_pkg::SH_LSR: begin
						if (amt < 32) begin co = x[amt-1]; r = x >> amt; end
						else begin co = (amt == 32) ? x[31] : 1'b0; r = '0; end
					end
					tdpu_pkg::SH_ASR: begin
						if (amt < 32) begin co = x[amt-1]; r = $signed(x) >>> amt; end
						else begin co = x[31]; r = {32{x[31]}}; end
					end
					default: begin
						m = amt % 32;
						r = (m == 0) ? x : ((x >> m) | (x << (32 - m)));
						co = r[31];
					end
				endcase
			end
			return r;
		endfunction

		function void note_item(tdpu_pkg::item_t it);
			tdpu_pkg::result_t e;
			logic [15:0] w;
			logic [31:0] a, b, d, s, r;
			logic [3:0] f;
			logic c, ci, vi;
			int unsigned amt;
			w = it.instruction;
			f = nzcv;
			ci = nzcv[1];
			vi = nzcv[0];
			e = '0;
			r = '0;
			if (it.command) begin
				e.dest_register = it.load_index;
				r = it.load_value;
				e.register_written = 1'b1;
			end else if (w[15:13] == 3'b000 && w[12:11] != 2'b11) begin
				amt = 32'(w[10:6]);
				if (w[12:11] != tdpu_pkg::SH_LSL && amt == 0) amt = 32;
				e.dest_register = w[2:0];
				r = shifter(w[12:11], regs[w[5:3]], amt, ci, c);
				f = nz(r, c, vi);
				e.register_written = 1'b1;
			end else if (w[15:11] == 5'b00011) begin
				a = regs[w[5:3]];
				b = w[10] ? {29'd0, w[8:6]} : regs[w[8:6]];
				e.dest_register = w[2:0];
				f = w[9] ? sub(a, b, 1'b0, r) : add(a, b, 1'b0, r);
				e.register_written = 1'b1;
			end else if (w[15:13] == 3'b001) begin
				e.dest_register = w[10:8];
				a = regs[w[10:8]];
				b = {24'd0, w[7:0]};
				e.register_written = 1'b1;
				case (w[12:11])
					2'd0: begin r = b; f = nz(r, ci, vi); end
					2'd1: begin f = sub(a, b, 1'b0, r); e.register_written = 1'b0; end
					2'd2: f = add(a, b, 1'b0, r);
					default: f = sub(a, b, 1'b0, r);
				endcase
			end else if (w[15:10] == 6'b010000) begin
				s = regs[w[5:3]];
				d = regs[w[2:0]];
				e.dest_register = w[2:0];
				e.register_written = 1'b1;
				case (tdpu_pkg::alu_op_t'(w[9:6]))
					tdpu_pkg::ALU_AND: begin r = d & s; f = nz(r, ci, vi); end
					tdpu_pkg::ALU_EOR: begin r = d ^ s; f = nz(r, ci, vi); end
					tdpu_pkg::ALU_LSL: begin
						r = shifter(tdpu_pkg::SH_LSL, d, 32'(s[7:0]), ci, c);
						f = nz(r, c, vi);
					end
					tdpu_pkg::ALU_LSR: begin
						r = shifter(tdpu_pkg::SH_LSR, d, 32'(s[7:0]), ci, c);
						f = nz(r, c, vi);
					end
					tdpu_pkg::ALU_ASR: begin
						r = shifter(tdpu_pkg::SH_ASR, d, 32'(s[7:0]), ci, c);
						f = nz(r, c, vi);
					end
					tdpu_pkg::ALU_ADC: f = add(d, s, ci, r);
					tdpu_pkg::ALU_SBC: f = sub(d, s, ~ci, r);
					tdpu_pkg::ALU_ROR: begin
						r = shifter(tdpu_pkg::SH_ROR, d, 32'(s[7:0]), ci, c);
						f = nz(r, c, vi);
					end
					tdpu_pkg::ALU_TST: begin
						r = d & s;
						f = nz(r, ci, vi);
						e.register_written = 1'b0;
					end
					tdpu_pkg::ALU_NEG: f = sub(32'd0, s, 1'b0, r);
					tdpu_pkg::ALU_CMP: begin
						f = sub(d, s, 1'b0, r);
						e.register_written = 1'b0;
					end
					tdpu_pkg::ALU_CMN: begin
						f = add(d, s, 1'b0, r);
						e.register_written = 1'b0;
					end
					tdpu_pkg::ALU_ORR: begin r = d | s; f = nz(r, ci, vi); end
					tdpu_pkg::ALU_MUL: begin r = d * s; f = nz(r, 1'b0, vi); end
					tdpu_pkg::ALU_BIC: begin r = d & ~s; f = nz(r, ci, vi); end
					default: begin r = ~s; f = nz(r, ci, vi); end
				endcase
			end else begin
				e.unhandled = 1'b1;
			end
			if (e.register_written) regs[e.dest_register] = r;
			nzcv = f;
			e.result_value = r;
			{e.flag_negative, e.flag_zero, e.flag_carry, e.flag_overflow} = f;
			pending.push_back(e);
		endfunction

		task check_result(tdpu_pkg::result_t got);
			tdpu_pkg::result_t e;
			if (pending.size() == 0) begin
				report("unexpected result", got.result_value, 32'd0);
				return;
			end
			e = pending.pop_front();
			if (got.result_value !== e.result_value)
				report("result_value", got.result_value, e.result_value);
			if (got.dest_register !== e.dest_register)
				report("dest_register", 32'(got.dest_register), 32'(e.dest_register));
			if (got.register_written !== e.register_written)
				report("register_written", 32'(got.register_written),
					32'(e.register_written));
			if (got.flag_negative !== e.flag_negative)
				report("flag_negative", 32'(got.flag_negative), 32'(e.flag_negative));
			if (got.flag_zero !== e.flag_zero)
				report("flag_zero", 32'(got.flag_zero), 32'(e.flag_zero));
			if (got.flag_carry !== e.flag_carry)
				report("flag_carry", 32'(got.flag_carry), 32'(e.flag_carry));
			if (got.flag_overflow !== e.flag_overflow)
				report("flag_overflow", 32'(got.flag_overflow), 32'(e.flag_overflow));
			if (got.unhandled !== e.unhandled)
				report("unhandled", 32'(got.unhandled), 32'(e.unhandled));
		endtask
	endclass

	alu_scoreboard sb = new();
	int sent = 0;
	int received = 0;
	bit stall_gaps = 1'b1;
	bit long_hold = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sink side: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = stall_gaps ? $urandom_range(0, 18) : 0;
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_result(out_ch.data);
			received++;
		end
	end

	task automatic send_item(input tdpu_pkg::item_t it, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	task automatic send_ins(input logic [15:0] w);
		tdpu_pkg::item_t it;
		it = '0;
		it.instruction = w;
		it.load_index = 3'($urandom);
		it.load_value = $urandom;
		send_item(it, 0);
	endtask

	task automatic send_load(input logic [2:0] idx, input logic [31:0] v);
		tdpu_pkg::item_t it;
		it = '0;
		it.command = 1'b1;
		it.load_index = idx;
		it.load_value = v;
		it.instruction = 16'($urandom);
		send_item(it, 0);
	endtask

	function automatic logic [15:0] random_ins();
		logic [15:0] w;
		w = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1: w[15:13] = 3'b000;
			2: w[15:11] = 5'b00011;
			3, 4: w[15:13] = 3'b001;
			5, 6, 7: w[15:10] = 6'b010000;
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 40);
			4: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		tdpu_pkg::item_t it;
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: extremes, zero and 32 shift amounts, compares, multiply, unhandled.
		send_load(3'd0, 32'hFFFF_FFFF);
		send_load(3'd1, 32'd32);
		send_load(3'd2, 32'h8000_0001);
		send_load(3'd7, 32'd33);
		send_ins(16'h0008);                  // LSL #0 r0,r1
		send_ins(16'h0810);                  // LSR #0 -> 32
		send_ins(16'h1010);                  // ASR #0 -> 32
		send_ins({6'b010000, tdpu_pkg::ALU_LSL, 3'd1, 3'd2});
		send_ins({6'b010000, tdpu_pkg::ALU_LSR, 3'd7, 3'd0});
		send_ins({6'b010000, tdpu_pkg::ALU_ROR, 3'd1, 3'd2});
		send_ins({6'b010000, tdpu_pkg::ALU_ASR, 3'd7, 3'd2});
		send_load(3'd5, 32'd0);
		send_ins({6'b010000, tdpu_pkg::ALU_LSL, 3'd5, 3'd0});
		send_ins(16'h2AFF);                  // CMP r2,#255
		send_ins(16'h23FF);                  // MOV r3,#255
		send_ins(16'h1FFF);                  // SUB r7,r7,#7
		send_ins({6'b010000, tdpu_pkg::ALU_MUL, 3'd0, 3'd3});
		send_ins({6'b010000, tdpu_pkg::ALU_TST, 3'd0, 3'd2});
		send_ins({6'b010000, tdpu_pkg::ALU_CMN, 3'd0, 3'd0});
		send_ins({6'b010000, tdpu_pkg::ALU_NEG, 3'd5, 3'd4});
		send_ins({6'b010000, tdpu_pkg::ALU_SBC, 3'd0, 3'd6});
		send_ins({6'b010000, tdpu_pkg::ALU_MVN, 3'd0, 3'd6});
		send_ins(16'hFFFF);
		send_ins(16'h4700);                  // high-register op, unhandled
		for (int k = 0; k < 600; k++) begin
			if (k == 200) long_hold = 1'b1;
			if (k == 400) begin
				// Pause until every expected result has drained.
				in_ch.valid <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			stall_gaps = !(k >= 450 && k < 500);
			it = '0;
			if ($urandom_range(0, 4) == 0) begin
				it.command = 1'b1;
				it.load_value = random_value();
				it.instruction = 16'($urandom);
			end else begin
				it.instruction = random_ins();
				it.load_value = $urandom;
			end
			it.load_index = 3'($urandom);
			gap = stall_gaps ? $urandom_range(0, 18) : 0;
			if ($urandom_range(0, 2) == 0) gap = 0;
			send_item(it, gap);
		end
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d items (loads, shifts, add/sub, immediates, ALU ops, unhandled),", sent);
		$display("%0d results checked under random stalls and one long output hold-off.", received);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
